/* src/gyr_pkg.sv */
`default_nettype none

package gyr_pkg;

  // Number formats.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned DT_W      = TIME_W + 1;
  localparam int unsigned ERR_W     = DATA_W + 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Digit-serial multiplier geometry.
  localparam int unsigned MUL_W  = DT_W + 1;
  localparam int unsigned DIG_W  = 16;
  localparam int unsigned N_DIG  = (MUL_W + DIG_W - 1) / DIG_W;
  localparam int unsigned MCNT_W = $clog2(N_DIG);
  localparam int unsigned ACC_W  = MUL_W + 1;
  localparam int unsigned LOW_W  = N_DIG * DIG_W;
  localparam int unsigned PROD_W = ACC_W + LOW_W;

  // Restoring divider geometry.
  localparam int unsigned QUO_W  = 2 * DATA_W;
  localparam int unsigned DCNT_W = $clog2(QUO_W);

  // Constants rounded to nearest from 32 fraction bits.
  localparam logic [63:0] PI_RAW =
    (64'h3243F6A88 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [63:0] TWO_PI_RAW =
    (64'h6487ED511 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [63:0] NOISE_RAW =
    (64'h1999999A + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [63:0] NOISE15_RAW =
    (64'h26666666 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

  localparam logic signed [ERR_W-1:0] PI_Q     = ERR_W'(PI_RAW);
  localparam logic signed [ERR_W-1:0] TWO_PI_Q = ERR_W'(TWO_PI_RAW);
  localparam logic [DATA_W-1:0]       NOISE_Q   = DATA_W'(NOISE_RAW);
  localparam logic [DATA_W-1:0]       NOISE15_Q = DATA_W'(NOISE15_RAW);

  // Register reset values.
  localparam logic [GAIN_W-1:0] ANGLE_P_RST = GAIN_W'(1) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] ANGLE_I_RST = '0;
  localparam logic [GAIN_W-1:0] RATE_P_RST  = GAIN_W'(1) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] LOCK_RST    = GAIN_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_P = 2'd0,
    CFG_ANGLE_I = 2'd1,
    CFG_RATE_P  = 2'd2,
    CFG_LOCK    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TIME_W-1:0]        time_stamp;
    logic signed [DATA_W-1:0] velocity_ref;
    logic signed [DATA_W-1:0] rate_ref;
    logic signed [DATA_W-1:0] rate_meas;
    logic signed [DATA_W-1:0] angle_meas;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rate_command;
    logic                     held;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MSTART,
    S_MWAIT,
    S_DWAIT,
    S_COMMIT
  } state_e;

  // Multiply steps: operand pair and destination of the result.
  typedef enum logic [2:0] {
    OP_INTEG,
    OP_APDT,
    OP_TE,
    OP_AIDT,
    OP_THI,
    OP_RPDT,
    OP_TERR,
    OP_SCALE
  } op_e;

  // How an item finishes.
  typedef enum logic [2:0] {
    K_FIRST,
    K_STOP,
    K_LATCH,
    K_HOLD0,
    K_HOLD1,
    K_CALC_Z,
    K_CALC_N,
    K_DIRECT
  } kind_e;

  typedef struct packed {
    logic  capture;
    op_e   op;
    logic  mul_start;
    logic  mul_wr;
    logic  commit;
    kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic ref_zero;
    logic vel_zero;
    logic straight;
    logic meas_same;
    logic run;
    logic need_scale;
    logic mul_done;
    logic div_done;
  } dp_stat_t;

  // Saturating signed add.
  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

  // Apply a sign to a magnitude, saturating to the data range.
  function automatic logic signed [DATA_W-1:0] mag_sat(
    input logic              neg,
    input logic [PROD_W-1:0] m
  );
    logic [PROD_W-1:0] lim;
    logic [DATA_W-1:0] r;
    lim = neg ? (PROD_W'(1) << (DATA_W - 1))
              : ((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
    r = (m > lim) ? lim[DATA_W-1:0] : m[DATA_W-1:0];
    return neg ? (~r + DATA_W'(1)) : r;
  endfunction

endpackage

`default_nettype wire

/* src/gyro_yaw_rate_controller.sv */
// Channel | Direction | Handshake              | Beat
// --------+-----------+------------------------+-----------------------------
// in      | input     | in_valid_i/in_ready_o  | gyr_pkg::in_item_t
// out     | output    | out_valid_o/out_ready_i| gyr_pkg::out_item_t
// cfg     | input     | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// One item is in work at a time. Multiplies run in the digit-serial unit;
// a beat with no arithmetic due goes straight to commit, the rate loop and
// the heading loop each run a chain of multiplies, and a rescaled command
// adds a multiply followed by the 64-step divider.
// Reset is asynchronous and active low; the block takes beats right after.
// A result waits in the output register; the next beat is accepted
// meanwhile and finishes once that register has been read.
`default_nettype none

module gyro_yaw_rate_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gyr_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gyr_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [gyr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [gyr_pkg::GAIN_W-1:0]    cfg_data_i
);

  gyr_pkg::dp_cmd_t  cmd;
  gyr_pkg::dp_stat_t stat;

  // Sequencer.
  gyr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  gyr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire

/* src/gyr_mul.sv */
`default_nettype none

// Digit-serial signed multiplier: one DIG_W-bit digit of b per cycle.
module gyr_mul (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic signed [gyr_pkg::MUL_W-1:0] a_i,
  input  wire logic signed [gyr_pkg::MUL_W-1:0] b_i,
  output logic                                 done_o,
  output logic                                 neg_o,
  output logic [gyr_pkg::PROD_W-1:0]           prod_o
);

  localparam int unsigned SUM_W = gyr_pkg::MUL_W + gyr_pkg::DIG_W + 1;

  logic [gyr_pkg::MUL_W-1:0]  a_q;
  logic [gyr_pkg::LOW_W-1:0]  b_q;
  logic [gyr_pkg::ACC_W-1:0]  acc_q;
  logic [gyr_pkg::LOW_W-1:0]  low_q;
  logic                       neg_q;
  logic [gyr_pkg::MCNT_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic [gyr_pkg::MUL_W-1:0]               a_mag;
  logic [gyr_pkg::MUL_W-1:0]               b_mag;
  logic [gyr_pkg::MUL_W+gyr_pkg::DIG_W-1:0] pp;
  logic [SUM_W-1:0]                        sum;

  assign a_mag = a_i[gyr_pkg::MUL_W-1] ? (~a_i + gyr_pkg::MUL_W'(1)) : a_i;
  assign b_mag = b_i[gyr_pkg::MUL_W-1] ? (~b_i + gyr_pkg::MUL_W'(1)) : b_i;

  // One partial product and accumulate per cycle.
  assign pp  = {{gyr_pkg::DIG_W{1'b0}}, a_q} *
               {{gyr_pkg::MUL_W{1'b0}}, b_q[gyr_pkg::DIG_W-1:0]};
  assign sum = SUM_W'(acc_q) + SUM_W'(pp);

  // Sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= gyr_pkg::MCNT_W'(gyr_pkg::N_DIG - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - gyr_pkg::MCNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_mag;
      b_q   <= gyr_pkg::LOW_W'(b_mag);
      acc_q <= '0;
      low_q <= '0;
      neg_q <= a_i[gyr_pkg::MUL_W-1] ^ b_i[gyr_pkg::MUL_W-1];
    end else if (busy_q) begin
      acc_q <= sum[SUM_W-1:gyr_pkg::DIG_W];
      low_q <= {sum[gyr_pkg::DIG_W-1:0], low_q[gyr_pkg::LOW_W-1:gyr_pkg::DIG_W]};
      b_q   <= b_q >> gyr_pkg::DIG_W;
    end
  end

  assign done_o = done_q;
  assign neg_o  = neg_q;
  assign prod_o = {acc_q, low_q};

endmodule

`default_nettype wire

/* src/gyr_div.sv */
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module gyr_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [gyr_pkg::QUO_W-1:0]   dividend_i,
  input  wire logic [gyr_pkg::DATA_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [gyr_pkg::QUO_W-1:0]        quo_o
);

  logic [gyr_pkg::QUO_W-1:0]  dvd_q;
  logic [gyr_pkg::DATA_W-1:0] d_q;
  logic [gyr_pkg::DATA_W-1:0] rem_q;
  logic [gyr_pkg::DCNT_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic [gyr_pkg::DATA_W:0] rem_sh;
  logic [gyr_pkg::DATA_W:0] rem_sub;
  logic                     ge;

  assign rem_sh  = {rem_q, dvd_q[gyr_pkg::QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, d_q};
  assign ge      = rem_sh >= {1'b0, d_q};

  // Sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= gyr_pkg::DCNT_W'(gyr_pkg::QUO_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - gyr_pkg::DCNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend register shifts out and fills with quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      d_q   <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[gyr_pkg::DATA_W-1:0] : rem_sh[gyr_pkg::DATA_W-1:0];
      dvd_q <= {dvd_q[gyr_pkg::QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

`default_nettype wire

/* src/gyr_dp.sv */
`default_nettype none

// Datapath: configuration, controller state, operand selection and results.
module gyr_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire gyr_pkg::dp_cmd_t               cmd_i,
  output gyr_pkg::dp_stat_t                   stat_o,
  input  wire gyr_pkg::in_item_t              in_data_i,
  output gyr_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [gyr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [gyr_pkg::GAIN_W-1:0]     cfg_data_i
);

  localparam int unsigned DW = gyr_pkg::DATA_W;
  localparam int unsigned MW = gyr_pkg::MUL_W;

  // Configuration and persistent state.
  logic [gyr_pkg::GAIN_W-1:0] angle_p_q, angle_i_q, rate_p_q, lock_q;
  logic                       first_q, straight_q;
  logic signed [DW-1:0]       heading_q, integ_q, last_ref_q, last_meas_q, last_cmd_q;
  logic [gyr_pkg::TIME_W-1:0] last_time_q, jump_q;

  // Item and working registers.
  gyr_pkg::in_item_t    in_q;
  logic signed [DW-1:0] t_q, u_q, cmd_q;
  gyr_pkg::out_item_t   out_q;

  logic [gyr_pkg::TIME_W-1:0] ts;
  logic signed [DW-1:0]       ref_v, meas_v, ang_v;
  logic [DW-1:0]              mr, mp;
  logic [DW+1:0]              mr2, mr3, mp2, mp3;
  logic                       p_nz, same, flip, p_big, r_big15, ratio_jump;
  logic                       jump_ref, jump_scale, at_jump, run;
  logic [gyr_pkg::TIME_W-1:0] jt_new;
  logic [gyr_pkg::DT_W-1:0]   since_jump, dt;
  logic signed [gyr_pkg::ERR_W-1:0] e_raw, e_w1, e_v;
  logic [DW:0]                err_v;
  logic signed [DW-1:0]       direct_cmd, new_cmd, q_mul, q_div;
  logic                       is_hold, scale_neg;

  logic signed [MW-1:0]       op_a, op_b;
  logic                       mul_done, mul_neg, div_start, div_done;
  logic [gyr_pkg::PROD_W-1:0] mul_prod;
  logic [gyr_pkg::QUO_W-1:0]  quo;

  assign ts     = in_q.time_stamp;
  assign ref_v  = in_q.rate_ref;
  assign meas_v = in_q.rate_meas;
  assign ang_v  = in_q.angle_meas;

  // Jump detection on the rate reference.
  assign mr  = ref_v[DW-1] ? (~ref_v + DW'(1)) : ref_v;
  assign mp  = last_ref_q[DW-1] ? (~last_ref_q + DW'(1)) : last_ref_q;
  assign mr2 = {1'b0, mr, 1'b0};
  assign mp2 = {1'b0, mp, 1'b0};
  assign mr3 = {2'b00, mr} + {1'b0, mr, 1'b0};
  assign mp3 = {2'b00, mp} + {1'b0, mp, 1'b0};

  assign p_nz       = last_ref_q != '0;
  assign same       = p_nz && (ref_v[DW-1] == last_ref_q[DW-1]);
  assign flip       = p_nz && !same;
  assign p_big      = mp >= gyr_pkg::NOISE_Q;
  assign r_big15    = mr >= gyr_pkg::NOISE15_Q;
  assign ratio_jump = (mr2 > mp3) || (mp2 > mr3);
  assign jump_ref   = flip || (!p_big && r_big15);
  assign jump_scale = p_big && same && ratio_jump;
  assign jt_new     = (jump_ref || jump_scale) ? ts : jump_q;
  assign at_jump    = ts == jt_new;

  // Lock period check, signed time difference.
  assign since_jump = {1'b0, ts} - {1'b0, jt_new};
  assign run = $signed(since_jump) >=
               $signed({{(gyr_pkg::DT_W - gyr_pkg::GAIN_W){1'b0}}, lock_q});
  assign direct_cmd = (at_jump && jump_ref) ? ref_v : last_cmd_q;

  assign dt = {1'b0, ts} - {1'b0, last_time_q};

  // Heading error wrapped once into plus or minus pi.
  assign e_raw = {{2{heading_q[DW-1]}}, heading_q} - {{2{ang_v[DW-1]}}, ang_v};
  assign e_w1  = (e_raw > gyr_pkg::PI_Q) ? (e_raw - gyr_pkg::TWO_PI_Q) : e_raw;
  assign e_v   = (e_w1 < -gyr_pkg::PI_Q) ? (e_w1 + gyr_pkg::TWO_PI_Q) : e_w1;
  assign err_v = {ref_v[DW-1], ref_v} - {meas_v[DW-1], meas_v};

  // Status toward the controller.
  always_comb begin
    stat_o.first      = first_q;
    stat_o.ref_zero   = ref_v == '0;
    stat_o.vel_zero   = in_q.velocity_ref == '0;
    stat_o.straight   = straight_q;
    stat_o.meas_same  = meas_v == last_meas_q;
    stat_o.run        = run;
    stat_o.need_scale = !run && (at_jump ? jump_scale : (p_big && (ref_v != last_ref_q)));
    stat_o.mul_done   = mul_done;
    stat_o.div_done   = div_done;
  end

  // Multiplier operand selection.
  always_comb begin
    unique case (cmd_i.op)
      gyr_pkg::OP_INTEG: begin
        op_a = {{(MW - gyr_pkg::ERR_W){e_v[gyr_pkg::ERR_W-1]}}, e_v};
        op_b = {dt[gyr_pkg::DT_W-1], dt};
      end
      gyr_pkg::OP_APDT: begin
        op_a = {{(MW - gyr_pkg::GAIN_W){1'b0}}, angle_p_q};
        op_b = {dt[gyr_pkg::DT_W-1], dt};
      end
      gyr_pkg::OP_TE: begin
        op_a = {{(MW - DW){t_q[DW-1]}}, t_q};
        op_b = {{(MW - gyr_pkg::ERR_W){e_v[gyr_pkg::ERR_W-1]}}, e_v};
      end
      gyr_pkg::OP_AIDT: begin
        op_a = {{(MW - gyr_pkg::GAIN_W){1'b0}}, angle_i_q};
        op_b = {dt[gyr_pkg::DT_W-1], dt};
      end
      gyr_pkg::OP_THI: begin
        op_a = {{(MW - DW){t_q[DW-1]}}, t_q};
        op_b = {{(MW - DW){integ_q[DW-1]}}, integ_q};
      end
      gyr_pkg::OP_RPDT: begin
        op_a = {{(MW - gyr_pkg::GAIN_W){1'b0}}, rate_p_q};
        op_b = {dt[gyr_pkg::DT_W-1], dt};
      end
      gyr_pkg::OP_TERR: begin
        op_a = {{(MW - DW){t_q[DW-1]}}, t_q};
        op_b = {{(MW - DW - 1){err_v[DW]}}, err_v};
      end
      gyr_pkg::OP_SCALE: begin
        op_a = {{(MW - DW){last_cmd_q[DW-1]}}, last_cmd_q};
        op_b = {{(MW - DW){ref_v[DW-1]}}, ref_v};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  gyr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .neg_o   (mul_neg),
    .prod_o  (mul_prod)
  );

  // The divider takes the raw product of last command and reference.
  assign div_start = cmd_i.mul_wr && (cmd_i.op == gyr_pkg::OP_SCALE);

  gyr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_prod[gyr_pkg::QUO_W-1:0]),
    .divisor_i  (mp),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign q_mul     = gyr_pkg::mag_sat(mul_neg, mul_prod >> gyr_pkg::FRAC_BITS);
  assign scale_neg = ref_v[DW-1] ^ last_cmd_q[DW-1] ^ last_ref_q[DW-1];
  assign q_div     = p_nz ? gyr_pkg::mag_sat(scale_neg, gyr_pkg::PROD_W'(quo)) : last_cmd_q;

  // Command value of the finishing item.
  assign is_hold = (cmd_i.kind == gyr_pkg::K_HOLD0) || (cmd_i.kind == gyr_pkg::K_HOLD1);
  always_comb begin
    unique case (cmd_i.kind)
      gyr_pkg::K_FIRST:  new_cmd = ref_v;
      gyr_pkg::K_STOP:   new_cmd = '0;
      gyr_pkg::K_LATCH:  new_cmd = '0;
      gyr_pkg::K_CALC_Z: new_cmd = cmd_q;
      gyr_pkg::K_CALC_N: new_cmd = cmd_q;
      gyr_pkg::K_DIRECT: new_cmd = direct_cmd;
      gyr_pkg::K_HOLD0:  new_cmd = last_cmd_q;
      gyr_pkg::K_HOLD1:  new_cmd = last_cmd_q;
      default:           new_cmd = last_cmd_q;
    endcase
  end

  // Configuration and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_p_q   <= gyr_pkg::ANGLE_P_RST;
      angle_i_q   <= gyr_pkg::ANGLE_I_RST;
      rate_p_q    <= gyr_pkg::RATE_P_RST;
      lock_q      <= gyr_pkg::LOCK_RST;
      first_q     <= 1'b1;
      straight_q  <= 1'b0;
      heading_q   <= '0;
      integ_q     <= '0;
      last_ref_q  <= '0;
      last_meas_q <= '0;
      last_cmd_q  <= '0;
      last_time_q <= '0;
      jump_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (gyr_pkg::cfg_idx_e'(cfg_index_i))
          gyr_pkg::CFG_ANGLE_P: angle_p_q <= cfg_data_i;
          gyr_pkg::CFG_ANGLE_I: angle_i_q <= cfg_data_i;
          gyr_pkg::CFG_RATE_P:  rate_p_q  <= cfg_data_i;
          gyr_pkg::CFG_LOCK:    lock_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.mul_wr && (cmd_i.op == gyr_pkg::OP_INTEG)) begin
        integ_q <= gyr_pkg::sat_add(integ_q, q_mul);
      end
      if (cmd_i.commit) begin
        if (!is_hold) begin
          last_ref_q  <= ref_v;
          last_meas_q <= meas_v;
          last_cmd_q  <= new_cmd;
          last_time_q <= ts;
        end
        unique case (cmd_i.kind)
          gyr_pkg::K_FIRST: begin
            first_q <= 1'b0;
            jump_q  <= '0;
          end
          gyr_pkg::K_STOP: straight_q <= 1'b0;
          gyr_pkg::K_LATCH: begin
            straight_q <= 1'b1;
            heading_q  <= ang_v;
            integ_q    <= '0;
          end
          gyr_pkg::K_HOLD1: jump_q <= jt_new;
          gyr_pkg::K_CALC_N, gyr_pkg::K_DIRECT: begin
            jump_q     <= jt_new;
            straight_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Item capture, intermediate products and the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul_wr) begin
      unique case (cmd_i.op)
        gyr_pkg::OP_APDT, gyr_pkg::OP_AIDT, gyr_pkg::OP_RPDT: t_q <= q_mul;
        gyr_pkg::OP_TE:   u_q   <= q_mul;
        gyr_pkg::OP_THI:  cmd_q <= gyr_pkg::sat_add(u_q, q_mul);
        gyr_pkg::OP_TERR: cmd_q <= gyr_pkg::sat_add(last_cmd_q, q_mul);
        default: ;
      endcase
    end
    if (div_done) begin
      cmd_q <= q_div;
    end
    if (cmd_i.commit) begin
      out_q.rate_command <= new_cmd;
      out_q.held         <= is_hold;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* src/gyr_ctrl.sv */
`default_nettype none

// Controller: sequences decision, multiply steps, division and result hand-off.
module gyr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire gyr_pkg::dp_stat_t stat_i,
  output gyr_pkg::dp_cmd_t       cmd_o
);

  gyr_pkg::state_e state_q, state_d;
  gyr_pkg::op_e    op_q, op_d;
  gyr_pkg::kind_e  kind_q, kind_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gyr_pkg::S_IDLE;
      op_q        <= gyr_pkg::OP_INTEG;
      kind_q      <= gyr_pkg::K_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    kind_d          = kind_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    cmd_o.capture   = 1'b0;
    cmd_o.op        = op_q;
    cmd_o.mul_start = 1'b0;
    cmd_o.mul_wr    = 1'b0;
    cmd_o.commit    = 1'b0;
    cmd_o.kind      = kind_q;

    unique case (state_q)
      gyr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = gyr_pkg::S_DECIDE;
        end
      end
      gyr_pkg::S_DECIDE: begin
        state_d = gyr_pkg::S_COMMIT;
        priority if (stat_i.first) begin
          kind_d = gyr_pkg::K_FIRST;
        end else if (stat_i.ref_zero && stat_i.vel_zero) begin
          kind_d = gyr_pkg::K_STOP;
        end else if (stat_i.ref_zero && !stat_i.straight) begin
          kind_d = gyr_pkg::K_LATCH;
        end else if (stat_i.ref_zero && stat_i.meas_same) begin
          kind_d = gyr_pkg::K_HOLD0;
        end else if (stat_i.ref_zero) begin
          kind_d  = gyr_pkg::K_CALC_Z;
          op_d    = gyr_pkg::OP_INTEG;
          state_d = gyr_pkg::S_MSTART;
        end else if (stat_i.run && stat_i.meas_same) begin
          kind_d = gyr_pkg::K_HOLD1;
        end else if (stat_i.run) begin
          kind_d  = gyr_pkg::K_CALC_N;
          op_d    = gyr_pkg::OP_RPDT;
          state_d = gyr_pkg::S_MSTART;
        end else if (stat_i.need_scale) begin
          kind_d  = gyr_pkg::K_CALC_N;
          op_d    = gyr_pkg::OP_SCALE;
          state_d = gyr_pkg::S_MSTART;
        end else begin
          kind_d = gyr_pkg::K_DIRECT;
        end
      end
      gyr_pkg::S_MSTART: begin
        cmd_o.mul_start = 1'b1;
        state_d         = gyr_pkg::S_MWAIT;
      end
      gyr_pkg::S_MWAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.mul_wr = 1'b1;
          unique case (op_q)
            gyr_pkg::OP_INTEG: begin
              op_d    = gyr_pkg::OP_APDT;
              state_d = gyr_pkg::S_MSTART;
            end
            gyr_pkg::OP_APDT: begin
              op_d    = gyr_pkg::OP_TE;
              state_d = gyr_pkg::S_MSTART;
            end
            gyr_pkg::OP_TE: begin
              op_d    = gyr_pkg::OP_AIDT;
              state_d = gyr_pkg::S_MSTART;
            end
            gyr_pkg::OP_AIDT: begin
              op_d    = gyr_pkg::OP_THI;
              state_d = gyr_pkg::S_MSTART;
            end
            gyr_pkg::OP_RPDT: begin
              op_d    = gyr_pkg::OP_TERR;
              state_d = gyr_pkg::S_MSTART;
            end
            gyr_pkg::OP_SCALE: state_d = gyr_pkg::S_DWAIT;
            gyr_pkg::OP_THI, gyr_pkg::OP_TERR: state_d = gyr_pkg::S_COMMIT;
            default: state_d = gyr_pkg::S_COMMIT;
          endcase
        end
      end
      gyr_pkg::S_DWAIT: begin
        if (stat_i.div_done) begin
          state_d = gyr_pkg::S_COMMIT;
        end
      end
      gyr_pkg::S_COMMIT: begin
        // Wait for the output register to be free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = gyr_pkg::S_IDLE;
        end
      end
      default: state_d = gyr_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o  = state_q == gyr_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* src/gyr_chk.sv */
`default_nettype none

// Port-level checks on the yaw-rate controller.
module gyr_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire gyr_pkg::out_item_t out_data_o
);

  logic signed [gyr_pkg::DATA_W-1:0] last_cmd_q;

  // Command of the last delivered beat that updated the state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cmd_q <= '0;
    end else if (out_valid_o && out_ready_i && !out_data_o.held) begin
      last_cmd_q <= out_data_o.rate_command;
    end
  end

  // A result stays offered until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped before it was taken");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Only one beat is in work: input closes right after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second input beat taken while one is in work");

  // A held result repeats the previous updated command.
  a_held_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.held |-> out_data_o.rate_command == last_cmd_q)
    else $error("held result differs from previous command");

endmodule

bind gyro_yaw_rate_controller gyr_chk u_gyr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
